>>> hdl/srt_pkg.sv
package srt_pkg;

    // Field widths
    localparam int REQ_W   = 2;
    localparam int ID_W    = 8;
    localparam int DATA_W  = 40;
    localparam int STAMP_W = 32;
    localparam int WORD_W  = DATA_W + STAMP_W;
    localparam int CHAR_W  = 8;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 9;
    localparam int EXP_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // Default sizing
    localparam int TABLE_DEPTH_DEF      = 256;
    localparam int TICKS_PER_MINUTE_DEF = 6000;

    // Register reset values
    localparam logic [CNT_W-1:0] SENSOR_COUNT_RST   = 9'd240;
    localparam logic [EXP_W-1:0] EXPIRY_MINUTES_RST = 8'd1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_MINUTES = 1'd1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_STORE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SWEEP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_CLEARED = 2'd2;

    localparam int HEX_DIGITS = DATA_W / 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_A    = 8'h41;

    // Control from the sequencer to the table memory
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr_one;
        logic clr_all;
    } t_mem_ctl;

    function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] nib);
        logic [CHAR_W-1:0] ext;
        ext = {4'b0000, nib};
        if (nib < 4'd10) begin
            return ASCII_ZERO + ext;
        end
        return ASCII_A + ext - 8'd10;
    endfunction

endpackage

>>> hdl/srt_cfg.sv
module srt_cfg #(
    parameter int TABLE_DEPTH      = srt_pkg::TABLE_DEPTH_DEF,
    parameter int TICKS_PER_MINUTE = srt_pkg::TICKS_PER_MINUTE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [srt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srt_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output logic [srt_pkg::CNT_W-1:0]       o_limit,
    output logic [srt_pkg::STAMP_W-1:0]     o_thresh
);

    localparam logic [srt_pkg::CNT_W-1:0] DEPTH_CNT = srt_pkg::CNT_W'(TABLE_DEPTH);

    logic [srt_pkg::CNT_W-1:0]   r_sensor_count;
    logic [srt_pkg::EXP_W-1:0]   r_expiry_minutes;
    logic [srt_pkg::STAMP_W-1:0] r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_count   <= srt_pkg::SENSOR_COUNT_RST;
            r_expiry_minutes <= srt_pkg::EXPIRY_MINUTES_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                srt_pkg::CFG_SENSOR_COUNT: begin
                    r_sensor_count <= i_cfg_wdata;
                end
                srt_pkg::CFG_EXPIRY_MINUTES: begin
                    r_expiry_minutes <= i_cfg_wdata[srt_pkg::EXP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Threshold product, registered before use
    always_ff @(posedge i_clk) begin
        r_thresh <= {{(srt_pkg::STAMP_W-srt_pkg::EXP_W){1'b0}}, r_expiry_minutes}
                    * srt_pkg::STAMP_W'(TICKS_PER_MINUTE);
    end

    assign o_limit  = (r_sensor_count > DEPTH_CNT) ? DEPTH_CNT : r_sensor_count;
    assign o_thresh = r_thresh;

endmodule

>>> hdl/srt_mem.sv
module srt_mem #(
    parameter int TABLE_DEPTH = srt_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srt_pkg::t_mem_ctl             i_ctl,
    input  logic [IDX_W-1:0]              i_addr,
    input  logic [IDX_W-1:0]              i_clr_idx,
    input  logic [srt_pkg::WORD_W-1:0]    i_wdata,
    output logic [srt_pkg::WORD_W-1:0]    o_rd_word
);

    logic [srt_pkg::WORD_W-1:0] r_mem [TABLE_DEPTH];
    logic [srt_pkg::WORD_W-1:0] r_rd_word;
    logic [TABLE_DEPTH-1:0]     r_valid;
    logic                       r_rd_vld;

    // Entry storage, one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rd_word <= r_mem[i_addr];
        end
    end

    // Per-entry valid flags; an invalid entry reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.rd) begin
                r_rd_vld <= r_valid[i_addr];
            end
            if (i_ctl.clr_all) begin
                r_valid <= '0;
            end else begin
                if (i_ctl.clr_one) begin
                    r_valid[i_clr_idx] <= 1'b0;
                end
                if (i_ctl.wr) begin
                    r_valid[i_addr] <= 1'b1;
                end
            end
        end
    end

    assign o_rd_word = r_rd_vld ? r_rd_word : '0;

endmodule

>>> hdl/srt_ctrl.sv
module srt_ctrl #(
    parameter int TABLE_DEPTH = srt_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [srt_pkg::REQ_W-1:0]     i_req_type,
    input  logic [srt_pkg::ID_W-1:0]      i_sensor_id,
    input  logic [srt_pkg::DATA_W-1:0]    i_report_data,
    input  logic [srt_pkg::STAMP_W-1:0]   i_now_tick,
    input  logic [srt_pkg::CNT_W-1:0]     i_limit,
    input  logic [srt_pkg::STAMP_W-1:0]   i_thresh,
    output srt_pkg::t_mem_ctl             o_mem_ctl,
    output logic [IDX_W-1:0]              o_mem_addr,
    output logic [IDX_W-1:0]              o_clr_idx,
    output logic [srt_pkg::WORD_W-1:0]    o_mem_wdata,
    input  logic [srt_pkg::WORD_W-1:0]    i_rd_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [srt_pkg::CHAR_W-1:0]    o_hex_char,
    output logic [srt_pkg::STAT_W-1:0]    o_status,
    output logic                          o_last
);

    localparam logic [srt_pkg::CNT_W-1:0] DEPTH_CNT = srt_pkg::CNT_W'(TABLE_DEPTH);
    localparam logic [3:0] LAST_DIG = 4'(srt_pkg::HEX_DIGITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_SWEEP,
        S_RDWAIT,
        S_HEX
    } t_state;

    t_state                        r_state, n_state;
    logic                          r_o_valid, n_o_valid;
    logic [srt_pkg::CHAR_W-1:0]    r_o_hex, n_o_hex;
    logic [srt_pkg::STAT_W-1:0]    r_o_status, n_o_status;
    logic                          r_o_last, n_o_last;
    logic [srt_pkg::STAT_W-1:0]    r_resp_status, n_resp_status;
    logic [srt_pkg::STAMP_W-1:0]   r_now, n_now;
    logic [srt_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                          r_pend, n_pend;
    logic [IDX_W-1:0]              r_pend_idx, n_pend_idx;
    logic                          r_any, n_any;
    logic [srt_pkg::DATA_W-1:0]    r_shift, n_shift;
    logic [3:0]                    r_dig, n_dig;

    logic                          accept;
    logic                          out_free;
    logic                          ld_last;
    logic [srt_pkg::CNT_W-1:0]     id_m1;
    logic                          id_zero;
    logic                          id_bad;
    logic [srt_pkg::STAMP_W-1:0]   stamp;
    logic [srt_pkg::STAMP_W-1:0]   age;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_o_valid || !i_stall;
    assign id_m1    = srt_pkg::CNT_W'(i_sensor_id) - 9'd1;
    assign id_zero  = (i_sensor_id == '0);
    assign id_bad   = id_m1 >= DEPTH_CNT;
    assign stamp    = i_rd_word[srt_pkg::STAMP_W-1:0];
    assign age      = r_now - stamp;

    always_comb begin
        n_state       = r_state;
        n_o_valid     = r_o_valid && i_stall;
        n_o_hex       = r_o_hex;
        n_o_status    = r_o_status;
        n_o_last      = r_o_last;
        n_resp_status = r_resp_status;
        n_now         = r_now;
        n_cnt         = r_cnt;
        n_pend        = 1'b0;
        n_pend_idx    = r_pend_idx;
        n_any         = r_any;
        n_shift       = r_shift;
        n_dig         = r_dig;
        o_mem_ctl     = '0;
        o_mem_addr    = id_m1[IDX_W-1:0];
        o_clr_idx     = r_pend_idx;
        o_mem_wdata   = {i_report_data, i_now_tick};
        ld_last       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_now         = i_now_tick;
                    n_resp_status = srt_pkg::ST_DONE;
                    case (i_req_type)
                        srt_pkg::REQ_STORE: begin
                            if (!id_zero && id_bad) begin
                                n_resp_status = srt_pkg::ST_REJECT;
                            end else if (!id_zero) begin
                                o_mem_ctl.wr = 1'b1;
                            end
                            n_state = S_RESP;
                        end
                        srt_pkg::REQ_SWEEP: begin
                            n_cnt   = '0;
                            n_any   = 1'b0;
                            n_state = S_SWEEP;
                        end
                        srt_pkg::REQ_CLEAR: begin
                            o_mem_ctl.clr_all = 1'b1;
                            n_state           = S_RESP;
                        end
                        srt_pkg::REQ_READ: begin
                            if (id_zero || id_bad) begin
                                n_resp_status = srt_pkg::ST_REJECT;
                                n_state       = S_RESP;
                            end else begin
                                o_mem_ctl.rd = 1'b1;
                                n_state      = S_RDWAIT;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_hex    = '0;
                    n_o_status = r_resp_status;
                    n_o_last   = 1'b1;
                    ld_last    = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SWEEP: begin
                // Issue one read per cycle, check the entry read last cycle
                if (r_cnt < i_limit) begin
                    o_mem_ctl.rd = 1'b1;
                    o_mem_addr   = r_cnt[IDX_W-1:0];
                    n_pend       = 1'b1;
                    n_pend_idx   = r_cnt[IDX_W-1:0];
                    n_cnt        = r_cnt + 9'd1;
                end
                if (r_pend && (stamp != '0) && (age >= i_thresh)) begin
                    o_mem_ctl.clr_one = 1'b1;
                    n_any             = 1'b1;
                end
                if (!r_pend && !(r_cnt < i_limit)) begin
                    n_resp_status = r_any ? srt_pkg::ST_CLEARED : srt_pkg::ST_DONE;
                    n_state       = S_RESP;
                end
            end
            S_RDWAIT: begin
                n_shift = i_rd_word[srt_pkg::WORD_W-1:srt_pkg::STAMP_W];
                n_dig   = '0;
                n_state = S_HEX;
            end
            S_HEX: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_hex    = srt_pkg::hex_ascii(r_shift[srt_pkg::DATA_W-1 -: 4]);
                    n_o_status = srt_pkg::ST_DONE;
                    n_o_last   = (r_dig == LAST_DIG);
                    n_shift    = {r_shift[srt_pkg::DATA_W-5:0], 4'h0};
                    n_dig      = r_dig + 4'd1;
                    if (r_dig == LAST_DIG) begin
                        ld_last = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_pend    <= n_pend;
        end
        r_o_hex       <= n_o_hex;
        r_o_status    <= n_o_status;
        r_o_last      <= n_o_last;
        r_resp_status <= n_resp_status;
        r_now         <= n_now;
        r_cnt         <= n_cnt;
        r_pend_idx    <= n_pend_idx;
        r_any         <= n_any;
        r_shift       <= n_shift;
        r_dig         <= n_dig;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_o_valid;
    assign o_hex_char = r_o_hex;
    assign o_status   = r_o_status;
    assign o_last     = r_o_last;

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_last |=> (r_state == S_IDLE))
        else $error("final result not followed by idle");

    a_pend_has_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(o_mem_ctl.rd))
        else $error("sweep check without a read issued");

    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_ctl.wr |-> (accept && (i_req_type == srt_pkg::REQ_STORE)))
        else $error("table write outside an accepted store");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEX) |-> (r_dig <= LAST_DIG))
        else $error("hex digit count overrun");

endmodule

>>> hdl/sensor_report_table_with_expiry.sv
// Results: store, clear-all and rejected requests pass through the response state into
//   the output register; a read passes through the table read and the read-wait state,
//   then gives one hex digit per cycle while the output does not stall.
// Requests: one at a time; a sweep reads min(sensor_count, depth) entries.
// Reset: synchronous active low; clears all entry valid flags at once, so the table
//   reads as empty right after reset, and loads sensor_count 240, expiry_minutes 1.
module sensor_report_table_with_expiry #(
    parameter int TABLE_DEPTH      = srt_pkg::TABLE_DEPTH_DEF,
    parameter int TICKS_PER_MINUTE = srt_pkg::TICKS_PER_MINUTE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration writes
    input  logic                            i_cfg_wr_en,
    input  logic [srt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srt_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Request channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [srt_pkg::REQ_W-1:0]       i_req_type,
    input  logic [srt_pkg::ID_W-1:0]        i_sensor_id,
    input  logic [srt_pkg::DATA_W-1:0]      i_report_data,
    input  logic [srt_pkg::STAMP_W-1:0]     i_now_tick,
    // Result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [srt_pkg::CHAR_W-1:0]      o_hex_char,
    output logic [srt_pkg::STAT_W-1:0]      o_status,
    output logic                            o_last
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Sweep limit and expiry threshold, both derived from config registers
    logic [srt_pkg::CNT_W-1:0]   limit;
    logic [srt_pkg::STAMP_W-1:0] thresh;

    // Table memory access: one address port shared by read and write,
    // plus a separate clear index used while a sweep reads ahead
    srt_pkg::t_mem_ctl           mem_ctl;
    logic [IDX_W-1:0]            mem_addr;
    logic [IDX_W-1:0]            clr_idx;
    logic [srt_pkg::WORD_W-1:0]  mem_wdata;
    logic [srt_pkg::WORD_W-1:0]  rd_word;

    srt_cfg #(
        .TABLE_DEPTH      (TABLE_DEPTH),
        .TICKS_PER_MINUTE (TICKS_PER_MINUTE)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_limit     (limit),
        .o_thresh    (thresh)
    );

    // Each entry holds {report, stamp}; a cleared entry is only marked invalid
    srt_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_addr    (mem_addr),
        .i_clr_idx (clr_idx),
        .i_wdata   (mem_wdata),
        .o_rd_word (rd_word)
    );

    // Sequencer: accepts one request, drives the table, then hands results
    // to its output register; the sweep overlaps the read of entry i+1 with
    // the age check of entry i, so no two accesses touch the same entry
    srt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_sensor_id   (i_sensor_id),
        .i_report_data (i_report_data),
        .i_now_tick    (i_now_tick),
        .i_limit       (limit),
        .i_thresh      (thresh),
        .o_mem_ctl     (mem_ctl),
        .o_mem_addr    (mem_addr),
        .o_clr_idx     (clr_idx),
        .o_mem_wdata   (mem_wdata),
        .i_rd_word     (rd_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hex_char    (o_hex_char),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule
